// File: sv/osc_pkg.sv
// Package: widths, register indexes and reset values for the overdrive chain
package osc_pkg;
  localparam int SampleWidth  = 24;
  localparam int CoefFracBits = 23;
  localparam int CoefWidth    = 24;
  localparam int LevelWidth   = 18;
  localparam int CfgIdxWidth  = 3;
  localparam int ClipFrac     = 24;
  localparam int GainFrac     = 16;

  typedef enum logic [2:0] {
    REG_HPF_GAIN = 3'd0,
    REG_HPF_POLE = 3'd1,
    REG_LPF_GAIN = 3'd2,
    REG_LPF_POLE = 3'd3,
    REG_DRIVE    = 3'd4,
    REG_LEVEL    = 3'd5
  } reg_idx_t;

  localparam logic [23:0] HpfGainRst = 24'd8011087;
  localparam logic [23:0] HpfPoleRst = 24'd7633574;
  localparam logic [23:0] LpfGainRst = 24'd1055840;
  localparam logic [23:0] LpfPoleRst = 24'd6276927;
  localparam logic [23:0] DriveRst   = 24'd655360;
  localparam logic [17:0] LevelRst   = 18'd52429;

  // datapath step codes issued by the controller
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_HP1, OP_HP2, OP_HPSAT, OP_DRIVE, OP_SQ, OP_NUMDEN,
    OP_DIVSTART, OP_DIVSTEP, OP_CLIPFIN, OP_LP1, OP_LP2, OP_LPSAT, OP_LEVEL, OP_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_sts_t;
endpackage

// File: sv/osc_if.sv
// Stream interface carrying one sample per beat
interface osc_if #(parameter int W = 24) (input logic clk);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/osc_dp.sv
// Datapath: filter state, shared multiplier, restoring divider for the clipper
module osc_dp #(
  parameter int SW = osc_pkg::SampleWidth,
  parameter int CF = osc_pkg::CoefFracBits
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  osc_pkg::dp_cmd_t      cmd,
  output osc_pkg::dp_sts_t      sts,
  input  logic signed [SW-1:0]  in_sample,
  output logic signed [SW-1:0]  out_sample,
  input  logic [23:0]           hpf_gain,
  input  logic [23:0]           hpf_pole,
  input  logic [23:0]           lpf_gain,
  input  logic [23:0]           lpf_pole,
  input  logic [23:0]           drive_gain,
  input  logic [17:0]           output_level
);
  localparam int AW = SW + 4;
  localparam int PW = 64;
  localparam int CL = osc_pkg::ClipFrac;
  localparam int D  = SW - 1 - CL;      // sample frac minus clip frac
  localparam int GF = osc_pkg::GainFrac;
  localparam int AB = 28;                // |u| <= 3 in 24 frac bits: 26 bits
  localparam int QW = 2 * AB + 8;        // numerator width
  localparam int DW = CL + 8;            // denominator width
  localparam int CW = $clog2(QW + 1);
  localparam int MA = AB + 1;            // multiplier operand widths
  localparam int MB = (AW + 1 > CL + 8) ? AW + 1 : CL + 8;

  logic signed [SW-1:0] x_r, hp_in_r, lp_in_r, c_r, out_r;
  logic signed [AW-1:0] hp_out_r, lp_out_r, acc_sat;
  logic signed [PW-1:0] acc_r, prod, acc_rnd;
  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [MA+MB-1:0] mul_p;
  logic [AB-1:0]        a_r;
  logic [CL+8:0]        x2_r;
  logic [QW-1:0]        num_r, quo_r;
  logic [DW-1:0]        den_r;
  logic [DW:0]          rem_r, rem_try;
  logic [CW-1:0]        cnt_r;
  logic                 neg_r, big_r;

  // one multiplier, operands selected by the step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      osc_pkg::OP_HP1: begin
        mul_a = MA'($signed({1'b0, hpf_gain}));
        mul_b = MB'(x_r) - MB'(hp_in_r);
      end
      osc_pkg::OP_HP2: begin
        mul_a = MA'($signed({1'b0, hpf_pole}));
        mul_b = MB'(hp_out_r);
      end
      osc_pkg::OP_DRIVE: begin
        mul_a = MA'($signed({1'b0, drive_gain}));
        mul_b = MB'(hp_out_r);
      end
      osc_pkg::OP_SQ: begin
        mul_a = MA'($signed({1'b0, a_r}));
        mul_b = MB'($signed({1'b0, a_r}));
      end
      osc_pkg::OP_NUMDEN: begin
        mul_a = MA'($signed({1'b0, a_r}));
        mul_b = MB'($signed({1'b0, x2_r})) + (MB'(27) <<< CL);
      end
      osc_pkg::OP_LP1: begin
        mul_a = MA'($signed({1'b0, lpf_gain}));
        mul_b = MB'(c_r) + MB'(lp_in_r);
      end
      osc_pkg::OP_LP2: begin
        mul_a = MA'($signed({1'b0, lpf_pole}));
        mul_b = MB'(lp_out_r);
      end
      osc_pkg::OP_LEVEL: begin
        mul_a = MA'($signed({1'b0, output_level}));
        mul_b = MB'(lp_out_r);
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;
  assign prod  = PW'(mul_p);

  // filter accumulator rounding and saturation
  assign acc_rnd = (acc_r + (PW'(1) <<< (CF - 1))) >>> CF;
  always_comb begin
    if (acc_rnd > PW'((64'sd1 <<< (AW - 1)) - 1))
      acc_sat = {1'b0, {(AW-1){1'b1}}};
    else if (acc_rnd < -(PW'(1) <<< (AW - 1)))
      acc_sat = {1'b1, {(AW-1){1'b0}}};
    else
      acc_sat = acc_rnd[AW-1:0];
  end

  assign rem_try = {rem_r[DW-1:0], quo_r[QW-1]} - {1'b0, den_r};

  // result staging
  logic signed [PW-1:0] u_full, lv_full;
  logic [PW-1:0]        u_abs;
  logic [QW:0]          qfin;
  logic signed [PW-1:0] csig;
  always_comb begin
    u_full = (prod + (PW'(1) <<< (GF - 1))) >>> GF;
    u_abs  = u_full[PW-1] ? PW'(-u_full) : PW'(u_full);
    lv_full = (prod + (PW'(1) <<< (GF - 1))) >>> GF;
    if (D > 0) qfin = {1'b0, quo_r} << D;
    else if (D < 0) qfin = ({1'b0, quo_r} + ((QW+1)'(1) << (-D - 1))) >> (-D);
    else qfin = {1'b0, quo_r};
    csig = neg_r ? -PW'($signed({1'b0, qfin})) : PW'($signed({1'b0, qfin}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hp_in_r  <= '0;
      hp_out_r <= '0;
      lp_in_r  <= '0;
      lp_out_r <= '0;
    end else begin
      case (cmd.op)
        osc_pkg::OP_LOAD: x_r <= in_sample;
        osc_pkg::OP_HP1, osc_pkg::OP_LP1: acc_r <= prod;
        osc_pkg::OP_HP2, osc_pkg::OP_LP2: acc_r <= acc_r + prod;
        osc_pkg::OP_HPSAT: begin
          hp_out_r <= acc_sat;
          hp_in_r  <= x_r;
        end
        osc_pkg::OP_DRIVE: begin
          neg_r <= u_full[PW-1];
          big_r <= u_abs > (PW'(3) << (SW - 1));
          if (D > 0) a_r <= AB'((u_abs + (PW'(1) << (D - 1))) >> D);
          else a_r <= AB'(u_abs << (-D));
        end
        osc_pkg::OP_SQ: x2_r <= (CL+9)'((prod + (PW'(1) <<< (CL - 1))) >>> CL);
        osc_pkg::OP_NUMDEN: begin
          den_r <= DW'((27 << CL) + 9 * {1'b0, x2_r});
          num_r <= QW'(prod);
        end
        osc_pkg::OP_DIVSTART: begin
          // rounded division: (num + den/2) / den
          quo_r <= num_r + QW'(den_r >> 1);
          rem_r <= '0;
          cnt_r <= CW'(QW);
        end
        osc_pkg::OP_DIVSTEP: begin
          if (!rem_try[DW]) begin
            rem_r <= rem_try;
            quo_r <= {quo_r[QW-2:0], 1'b1};
          end else begin
            rem_r <= {rem_r[DW-1:0], quo_r[QW-1]};
            quo_r <= {quo_r[QW-2:0], 1'b0};
          end
          cnt_r <= cnt_r - 1'b1;
        end
        osc_pkg::OP_CLIPFIN: begin
          if (big_r)
            c_r <= neg_r ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
          else if (csig > PW'((64'sd1 <<< (SW - 1)) - 1))
            c_r <= {1'b0, {(SW-1){1'b1}}};
          else if (csig < -(PW'(1) <<< (SW - 1)))
            c_r <= {1'b1, {(SW-1){1'b0}}};
          else
            c_r <= csig[SW-1:0];
        end
        osc_pkg::OP_LPSAT: begin
          lp_out_r <= acc_sat;
          lp_in_r  <= c_r;
        end
        osc_pkg::OP_LEVEL: begin
          if (lv_full > PW'((64'sd1 <<< (SW - 1)) - 1))
            out_r <= {1'b0, {(SW-1){1'b1}}};
          else if (lv_full < -(PW'(1) <<< (SW - 1)))
            out_r <= {1'b1, {(SW-1){1'b0}}};
          else
            out_r <= lv_full[SW-1:0];
        end
        default: ;
      endcase
    end
  end

  assign sts.div_done = (cnt_r == CW'(1));
  assign out_sample   = out_r;
endmodule

// File: sv/osc_ctrl.sv
// Controller: sequences one sample through the datapath steps
module osc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output osc_pkg::dp_cmd_t cmd,
  input  osc_pkg::dp_sts_t sts
);
  typedef enum logic [3:0] {
    S_IDLE, S_HP1, S_HP2, S_HPSAT, S_DRIVE, S_SQ, S_ND, S_DSTART, S_DIV,
    S_CFIN, S_LP1, S_LP2, S_LPSAT, S_LEVEL, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   ovld_r, ovld_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ovld_r;

  // step command for the current state
  always_comb begin
    unique case (state_r)
      S_IDLE:   cmd.op = (in_valid && in_ready) ? osc_pkg::OP_LOAD : osc_pkg::OP_NONE;
      S_HP1:    cmd.op = osc_pkg::OP_HP1;
      S_HP2:    cmd.op = osc_pkg::OP_HP2;
      S_HPSAT:  cmd.op = osc_pkg::OP_HPSAT;
      S_DRIVE:  cmd.op = osc_pkg::OP_DRIVE;
      S_SQ:     cmd.op = osc_pkg::OP_SQ;
      S_ND:     cmd.op = osc_pkg::OP_NUMDEN;
      S_DSTART: cmd.op = osc_pkg::OP_DIVSTART;
      S_DIV:    cmd.op = osc_pkg::OP_DIVSTEP;
      S_CFIN:   cmd.op = osc_pkg::OP_CLIPFIN;
      S_LP1:    cmd.op = osc_pkg::OP_LP1;
      S_LP2:    cmd.op = osc_pkg::OP_LP2;
      S_LPSAT:  cmd.op = osc_pkg::OP_LPSAT;
      S_LEVEL:  cmd.op = (ovld_r && !out_ready) ? osc_pkg::OP_NONE : osc_pkg::OP_LEVEL;
      default:  cmd.op = osc_pkg::OP_NONE;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    ovld_nxt  = ovld_r && !out_ready;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_HP1;
      S_HP1:    state_nxt = S_HP2;
      S_HP2:    state_nxt = S_HPSAT;
      S_HPSAT:  state_nxt = S_DRIVE;
      S_DRIVE:  state_nxt = S_SQ;
      S_SQ:     state_nxt = S_ND;
      S_ND:     state_nxt = S_DSTART;
      S_DSTART: state_nxt = S_DIV;
      S_DIV:    if (sts.div_done) state_nxt = S_CFIN;
      S_CFIN:   state_nxt = S_LP1;
      S_LP1:    state_nxt = S_LP2;
      S_LP2:    state_nxt = S_LPSAT;
      S_LPSAT:  state_nxt = S_LEVEL;
      S_LEVEL: begin
        // output register must be free before it is overwritten
        if (!(ovld_r && !out_ready)) begin
          ovld_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end
endmodule

// File: sv/overdrive_softclip_tone_chain_core.sv
// Top level: config registers, controller and datapath of the overdrive chain
//  channel | dir | beat
//  in_     | in  | sample_in, signed Q1.23
//  out_    | out | sample_out, signed Q1.23
//  cfg_    | in  | register write, index + 24-bit data
// A sample passes through 12 sequencing steps plus 64 steps of the restoring
// divider in the clipper. No new sample is accepted until the last one is
// done; the input is held off meanwhile.
// The result waits in an output register; only the final store stalls if the
// previous result is still not taken.
// Reset is synchronous, active low; clears filter state, loads config defaults.
module overdrive_softclip_tone_chain_core #(
  parameter int SAMPLE_WIDTH   = osc_pkg::SampleWidth,
  parameter int COEF_FRAC_BITS = osc_pkg::CoefFracBits
) (
  input  logic        clk,
  input  logic        rst_n,
  osc_if.sink         in_ch,
  osc_if.source       out_ch,
  input  logic        cfg_we,
  input  logic [osc_pkg::CfgIdxWidth-1:0] cfg_idx,
  input  logic [23:0] cfg_data
);
  logic [23:0] hpf_gain_r, hpf_pole_r, lpf_gain_r, lpf_pole_r, drive_r;
  logic [17:0] level_r;
  osc_pkg::dp_cmd_t cmd;
  osc_pkg::dp_sts_t sts;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hpf_gain_r <= osc_pkg::HpfGainRst;
      hpf_pole_r <= osc_pkg::HpfPoleRst;
      lpf_gain_r <= osc_pkg::LpfGainRst;
      lpf_pole_r <= osc_pkg::LpfPoleRst;
      drive_r    <= osc_pkg::DriveRst;
      level_r    <= osc_pkg::LevelRst;
    end else if (cfg_we) begin
      case (cfg_idx)
        osc_pkg::REG_HPF_GAIN: hpf_gain_r <= cfg_data;
        osc_pkg::REG_HPF_POLE: hpf_pole_r <= cfg_data;
        osc_pkg::REG_LPF_GAIN: lpf_gain_r <= cfg_data;
        osc_pkg::REG_LPF_POLE: lpf_pole_r <= cfg_data;
        osc_pkg::REG_DRIVE:    drive_r    <= cfg_data;
        osc_pkg::REG_LEVEL:    level_r    <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  osc_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd, .sts
  );

  osc_dp #(.SW(SAMPLE_WIDTH), .CF(COEF_FRAC_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_sample(in_ch.data), .out_sample(out_ch.data),
    .hpf_gain(hpf_gain_r), .hpf_pole(hpf_pole_r),
    .lpf_gain(lpf_gain_r), .lpf_pole(lpf_pole_r),
    .drive_gain(drive_r), .output_level(level_r)
  );
endmodule

// File: sv/osc_chk.sv
// Port-level checker for the overdrive chain, bound to the top level
module osc_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [23:0] out_data
);
  // a stalled result holds its data
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  // a sample is never accepted on back to back cycles
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted two samples in a row");
  // no result appears right after an accept
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result too early");
endmodule

bind overdrive_softclip_tone_chain_core osc_chk u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_data(out_ch.data)
);
